FILE: hdl/mmrc_pkg.sv
// Shared types, constants and the CRC-16/Modbus byte update for the reply checker.
package mmrc_pkg;

    localparam int unsigned FRAME_LEN  = 25;
    localparam int unsigned WORD_COUNT = 10;

    localparam logic [4:0]  POS_ADDR     = 5'd0;
    localparam logic [4:0]  POS_FUNC     = 5'd1;
    localparam logic [4:0]  POS_COUNT    = 5'd2;
    localparam logic [4:0]  POS_DATA_LO  = 5'd3;
    localparam logic [4:0]  POS_DATA_HI  = 5'd22;
    localparam logic [4:0]  POS_CRC_LO   = 5'd23;
    localparam logic [4:0]  POS_CRC_HI   = 5'd24;
    localparam logic [4:0]  POS_IDLE     = 5'd25;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
    localparam logic [7:0]  DATA_BYTES      = 8'd20;

    localparam logic [7:0]  DEV_ADDR_RESET = 8'd248;

    localparam logic [0:0]  REG_DEV_ADDRESS = 1'b0;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ADDR_ERR   = 3'd1,
        ST_FUNC_ERR   = 3'd2,
        ST_COUNT_ERR  = 3'd3,
        ST_CRC_ERR    = 3'd4
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] voltage_val;
        logic [31:0] current_val;
        logic [31:0] power_val;
        logic [31:0] energy_val;
        logic [15:0] frequency_val;
        logic [15:0] power_factor_raw;
        logic [15:0] alarm_val;
    } result_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: hdl/mmrc_frame_checker.sv
// Frame position tracking, running CRC, field checks and payload word capture.
module mmrc_frame_checker
    import mmrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic [7:0]  rx_byte,
    input  logic        frame_start,
    input  logic [7:0]  dev_address,
    output logic        last_byte,
    output logic        res_valid,
    output result_t     res
);

    logic [4:0]  byte_count_reg, byte_count_next;
    logic [15:0] crc_reg, crc_next;
    status_t     err_reg, err_next;
    logic [7:0]  crc_lo_reg;
    logic [15:0] words_reg [WORD_COUNT];

    logic [4:0]  pos;
    logic [15:0] crc_base;
    status_t     err_base;
    logic        active;
    logic [4:0]  data_off;
    logic [3:0]  word_idx;
    logic [15:0] crc_rx;

    assign pos      = frame_start ? POS_ADDR : byte_count_reg;
    assign crc_base = frame_start ? CRC_INIT : crc_reg;
    assign err_base = frame_start ? ST_OK : err_reg;
    assign active   = (pos < POS_IDLE);
    assign data_off = pos - POS_DATA_LO;
    assign word_idx = data_off[4:1];
    assign crc_rx   = {rx_byte, crc_lo_reg};

    // next byte would close a frame
    assign last_byte = (byte_count_reg == POS_CRC_HI);

    always_comb begin
        byte_count_next = frame_start ? POS_ADDR : byte_count_reg;
        crc_next        = crc_base;
        err_next        = err_base;
        if (active) begin
            byte_count_next = pos + 5'd1;
            if (pos <= POS_DATA_HI) begin
                crc_next = crc_feed(crc_base, rx_byte);
            end
            if (err_base == ST_OK) begin
                case (pos)
                    POS_ADDR:   if (rx_byte != dev_address) err_next = ST_ADDR_ERR;
                    POS_FUNC:   if (rx_byte != FUNC_READ_INPUT) err_next = ST_FUNC_ERR;
                    POS_COUNT:  if (rx_byte != DATA_BYTES) err_next = ST_COUNT_ERR;
                    POS_CRC_HI: if (crc_rx != crc_base) err_next = ST_CRC_ERR;
                    default:    err_next = err_base;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= POS_IDLE;
            crc_reg        <= CRC_INIT;
            err_reg        <= ST_OK;
            crc_lo_reg     <= 8'h00;
        end else if (accept) begin
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            err_reg        <= err_next;
            if (active && pos == POS_CRC_LO) begin
                crc_lo_reg <= rx_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && pos >= POS_DATA_LO && pos <= POS_DATA_HI) begin
            if (data_off[0]) begin
                words_reg[word_idx][7:0] <= rx_byte;
            end else begin
                words_reg[word_idx][15:8] <= rx_byte;
            end
        end
    end

    assign res_valid            = accept && active && (pos == POS_CRC_HI);
    assign res.status           = err_next;
    assign res.voltage_val      = words_reg[0];
    assign res.current_val      = {words_reg[2], words_reg[1]};
    assign res.power_val        = {words_reg[4], words_reg[3]};
    assign res.energy_val       = {words_reg[6], words_reg[5]};
    assign res.frequency_val    = words_reg[7];
    assign res.power_factor_raw = words_reg[8];
    assign res.alarm_val        = words_reg[9];

endmodule

FILE: hdl/modbus_meter_response_checker.sv
// Modbus RTU read-input-registers reply checker: top level with APB register and result register.
// Takes one reply byte per cycle on the s_ channel; s_frame_start marks byte 0 of a 25-byte
// frame. After byte 24 one result appears on the m_ channel, in the cycle after that byte is
// accepted: a status (first failed check of address, function code, byte count, CRC) and the
// ten payload words as received. Bytes outside a frame give no result. The CRC is updated a
// whole byte per cycle, so the input accepts an item every cycle; it stalls only while byte 24
// of a frame is due and the previous result still sits unread in the output register.
module modbus_meter_response_checker
    import mmrc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_frame_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_voltage_val,
    output logic [31:0] m_current_val,
    output logic [31:0] m_power_val,
    output logic [31:0] m_energy_val,
    output logic [15:0] m_frequency_val,
    output logic [15:0] m_power_factor_raw,
    output logic [15:0] m_alarm_val
);

    logic [7:0] dev_addr_reg;
    logic       m_valid_reg;
    result_t    res_reg;
    logic       accept;
    logic       last_byte;
    logic       res_valid;
    result_t    res;
    logic       out_free;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= DEV_ADDR_RESET;
        end else if (psel && penable && pwrite && paddr == {REG_DEV_ADDRESS, 2'b00}) begin
            dev_addr_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_DEV_ADDRESS) ? {24'h0, dev_addr_reg} : 32'h0;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = out_free || !last_byte;
    assign accept   = s_valid && s_ready;

    mmrc_frame_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .rx_byte       (s_rx_byte),
        .frame_start   (s_frame_start),
        .dev_address   (dev_addr_reg),
        .last_byte     (last_byte),
        .res_valid     (res_valid),
        .res           (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = res_reg.status;
    assign m_voltage_val      = res_reg.voltage_val;
    assign m_current_val      = res_reg.current_val;
    assign m_power_val        = res_reg.power_val;
    assign m_energy_val       = res_reg.energy_val;
    assign m_frequency_val    = res_reg.frequency_val;
    assign m_power_factor_raw = res_reg.power_factor_raw;
    assign m_alarm_val        = res_reg.alarm_val;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free)
        else $error("result overwrites an unread item");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> m_valid)
        else $error("finished result not presented");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= ST_CRC_ERR))
        else $error("status code out of range");

    a_only_last_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (last_byte && m_valid && !m_ready))
        else $error("input stalled without a pending result");
`endif

endmodule

FILE: tb/mmrc_tb_pkg.sv
// Reply scoreboard for the Modbus reply checker testbench: frame predictor and result checks.
package mmrc_tb_pkg;
    import mmrc_pkg::*;

    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c;
        for (int i = 0; i < 8; i++) begin
            r = (r >> 1) ^ ((r[0] ^ d[i]) ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    class reply_scoreboard;
        logic [7:0]  dev_addr;
        logic [4:0]  pos;
        logic [15:0] crc;
        status_t     first_err;
        logic [7:0]  crc_lo;
        logic [15:0] words [WORD_COUNT];
        result_t     pending_replies [$];
        int unsigned mismatches;

        function new();
            dev_addr   = DEV_ADDR_RESET;
            pos        = POS_IDLE;
            crc        = CRC_INIT;
            first_err  = ST_OK;
            crc_lo     = 8'h00;
            mismatches = 0;
            foreach (words[i]) words[i] = 16'h0000;
        endfunction

        function void set_dev_address(input logic [7:0] value);
            dev_addr = value;
        endfunction

        function int unsigned pending();
            return pending_replies.size();
        endfunction

        function void mark_failure(input status_t code);
            if (first_err == ST_OK) first_err = code;
        endfunction

        // advances the frame tracker by one accepted byte
        function void note_byte(input logic [7:0] b, input logic start);
            logic [4:0] off;
            result_t    r;
            if (start) begin
                pos       = POS_ADDR;
                crc       = CRC_INIT;
                first_err = ST_OK;
            end
            if (pos >= POS_IDLE) return;
            if (pos <= POS_DATA_HI) crc = crc16_byte(crc, b);
            if (pos == POS_ADDR) begin
                if (b != dev_addr) mark_failure(ST_ADDR_ERR);
            end else if (pos == POS_FUNC) begin
                if (b != FUNC_READ_INPUT) mark_failure(ST_FUNC_ERR);
            end else if (pos == POS_COUNT) begin
                if (b != DATA_BYTES) mark_failure(ST_COUNT_ERR);
            end else if (pos <= POS_DATA_HI) begin
                off = pos - POS_DATA_LO;
                if (!off[0]) begin
                    words[off[4:1]][15:8] = b;
                end else begin
                    words[off[4:1]][7:0] = b;
                end
            end else if (pos == POS_CRC_LO) begin
                crc_lo = b;
            end else begin
                if ({b, crc_lo} != crc) mark_failure(ST_CRC_ERR);
                r.status           = first_err;
                r.voltage_val      = words[0];
                r.current_val      = {words[2], words[1]};
                r.power_val        = {words[4], words[3]};
                r.energy_val       = {words[6], words[5]};
                r.frequency_val    = words[7];
                r.power_factor_raw = words[8];
                r.alarm_val        = words[9];
                pending_replies.push_back(r);
            end
            pos = pos + 5'd1;
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_reply(input result_t got);
            result_t want;
            if (pending_replies.size() == 0) begin
                $error("result with no item pending: status %0d", got.status);
                mismatches++;
                return;
            end
            want = pending_replies.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("voltage_val", 32'(want.voltage_val), 32'(got.voltage_val));
            compare_field("current_val", want.current_val, got.current_val);
            compare_field("power_val", want.power_val, got.power_val);
            compare_field("energy_val", want.energy_val, got.energy_val);
            compare_field("frequency_val", 32'(want.frequency_val), 32'(got.frequency_val));
            compare_field("power_factor_raw", 32'(want.power_factor_raw),
                          32'(got.power_factor_raw));
            compare_field("alarm_val", 32'(want.alarm_val), 32'(got.alarm_val));
        endfunction
    endclass

endpackage

FILE: tb/tb_modbus_meter_response_checker.sv
// Top-level testbench for the Modbus reply checker: stimulus, handshakes, watchdog.
module tb_modbus_meter_response_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import mmrc_pkg::*;
    import mmrc_tb_pkg::*;

    localparam logic [2:0]  ADDR_DEV    = 3'(4 * REG_DEV_ADDRESS);
    localparam int unsigned QUIET_LIMIT = 4000;

    typedef enum {
        FR_GOOD, FR_BAD_ADDR, FR_BAD_FUNC, FR_BAD_COUNT, FR_BAD_CRC,
        FR_MULTI, FR_TRUNC, FR_RANDOM
    } reply_kind_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte     = '0;
    logic        s_frame_start = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [2:0]  m_status;
    logic [15:0] m_voltage_val;
    logic [31:0] m_current_val;
    logic [31:0] m_power_val;
    logic [31:0] m_energy_val;
    logic [15:0] m_frequency_val;
    logic [15:0] m_power_factor_raw;
    logic [15:0] m_alarm_val;

    reply_scoreboard sb = new();
    logic [7:0]      cur_addr = DEV_ADDR_RESET;
    bit              calm = 1'b0;
    int unsigned     quiet = 0;

    modbus_meter_response_checker uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_rx_byte(s_rx_byte), .s_frame_start(s_frame_start),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_voltage_val(m_voltage_val),
        .m_current_val(m_current_val), .m_power_val(m_power_val),
        .m_energy_val(m_energy_val), .m_frequency_val(m_frequency_val),
        .m_power_factor_raw(m_power_factor_raw), .m_alarm_val(m_alarm_val)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 7);
    end

    always @(posedge aclk) begin
        result_t seen;
        if (aresetn) begin
            if (psel && penable && pwrite && pready && paddr == ADDR_DEV) begin
                sb.set_dev_address(pwdata[7:0]);
            end
            if (s_valid && s_ready) sb.note_byte(s_rx_byte, s_frame_start);
            if (m_valid && m_ready) begin
                seen.status           = status_t'(m_status);
                seen.voltage_val      = m_voltage_val;
                seen.current_val      = m_current_val;
                seen.power_val        = m_power_val;
                seen.energy_val       = m_energy_val;
                seen.frequency_val    = m_frequency_val;
                seen.power_factor_raw = m_power_factor_raw;
                seen.alarm_val        = m_alarm_val;
                sb.check_reply(seen);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("modbus_meter_response_checker verification failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        while (!calm && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_rx_byte     <= b;
        s_frame_start <= start;
        do @(posedge aclk); while (!s_ready);
    endtask

    // sender holds off until every expected result has come out
    task automatic drain_replies(input int unsigned settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic set_dev_address(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DEV;
        pwdata  <= {24'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_addr = value;
    endtask

    task automatic send_reply(input reply_kind_t kind, input bit patterned,
                              output int unsigned sent);
        logic [7:0]  frame [FRAME_LEN];
        logic [15:0] crc;
        bit          bad_addr, bad_func, bad_count, bad_crc;
        bad_addr  = kind == FR_BAD_ADDR  || (kind == FR_MULTI && $urandom_range(1) == 1);
        bad_func  = kind == FR_BAD_FUNC  || (kind == FR_MULTI && $urandom_range(1) == 1);
        bad_count = kind == FR_BAD_COUNT || (kind == FR_MULTI && $urandom_range(1) == 1);
        bad_crc   = kind == FR_BAD_CRC   || (kind == FR_MULTI && $urandom_range(1) == 1);
        frame[0] = bad_addr  ? cur_addr ^ 8'($urandom_range(1, 255)) : cur_addr;
        frame[1] = bad_func  ? FUNC_READ_INPUT ^ 8'($urandom_range(1, 255)) : FUNC_READ_INPUT;
        frame[2] = bad_count ? DATA_BYTES ^ 8'($urandom_range(1, 255)) : DATA_BYTES;
        for (int i = POS_DATA_LO; i <= POS_DATA_HI; i++) begin
            if (patterned) begin
                frame[i] = ((i - POS_DATA_LO) % 4 < 2) ? 8'hFF : 8'h00;
            end else begin
                frame[i] = 8'($urandom_range(255));
            end
        end
        if (kind == FR_RANDOM) begin
            foreach (frame[i]) frame[i] = 8'($urandom_range(255));
        end
        crc = CRC_INIT;
        for (int i = 0; i <= POS_DATA_HI; i++) crc = crc16_byte(crc, frame[i]);
        if (bad_crc) crc = crc ^ 16'($urandom_range(1, 65535));
        if (kind != FR_RANDOM) begin
            frame[POS_CRC_LO] = crc[7:0];
            frame[POS_CRC_HI] = crc[15:8];
        end
        sent = (kind == FR_TRUNC) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
        for (int i = 0; i < sent; i++) send_byte(frame[i], i == 0);
    endtask

    task automatic random_traffic(input int unsigned target);
        int unsigned counted, sent, pick;
        reply_kind_t kind;
        counted = 0;
        while (counted < target) begin
            pick = $urandom_range(99);
            if (pick >= 96) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)), 1'b0);
            end else begin
                if (pick < 55)      kind = FR_GOOD;
                else if (pick < 62) kind = FR_BAD_ADDR;
                else if (pick < 68) kind = FR_BAD_FUNC;
                else if (pick < 74) kind = FR_BAD_COUNT;
                else if (pick < 82) kind = FR_BAD_CRC;
                else if (pick < 86) kind = FR_MULTI;
                else if (pick < 92) kind = FR_TRUNC;
                else                kind = FR_RANDOM;
                send_reply(kind, 1'b0, sent);
                counted += sent;
            end
            if ($urandom_range(99) < 3) drain_replies(0);
        end
    endtask

    initial begin
        int unsigned sent;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // bytes before any start, a cut-off frame, a full frame, a trailing byte
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(DEV_ADDR_RESET, 1'b1);
        send_byte(FUNC_READ_INPUT, 1'b0);
        send_byte(DATA_BYTES, 1'b0);
        send_reply(FR_GOOD, 1'b1, sent);
        send_byte(8'hFF, 1'b0);
        drain_replies(4);

        set_dev_address(8'h00);
        random_traffic(325);
        drain_replies(4);

        set_dev_address(8'hFF);
        calm = 1'b1;
        random_traffic(325);
        calm = 1'b0;
        drain_replies(4);

        set_dev_address(8'($urandom_range(255)));
        random_traffic(325);
        drain_replies(4);

        set_dev_address(DEV_ADDR_RESET);
        random_traffic(325);
        drain_replies(10);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("modbus_meter_response_checker verification clean");
        end else begin
            $display("modbus_meter_response_checker verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/mmrc_pkg.sv
hdl/mmrc_frame_checker.sv
hdl/modbus_meter_response_checker.sv
tb/mmrc_tb_pkg.sv
tb/tb_modbus_meter_response_checker.sv
